// ----- design/fbsb_pkg.sv -----
// Package for the 4b/6b line decoder: payload types, code table and lookup.
// No dependencies; used by fbsb_dec_core and four_b_six_b_decoder_top.
package fbsb_pkg;

   localparam int SymbolWidth = 6;
   localparam int NibbleWidth = 4;
   localparam int CodeCount   = 16;

   // Line bits left over between bytes: at most five.
   localparam int LineBitsWidth  = 5;
   localparam int LineCountWidth = 3;

   typedef logic [SymbolWidth-1:0] symbol_type;
   typedef logic [NibbleWidth-1:0] nibble_type;

   localparam symbol_type SymTable [CodeCount] = '{
      6'd21, 6'd49, 6'd50, 6'd35, 6'd52, 6'd37, 6'd38, 6'd22,
      6'd26, 6'd25, 6'd42, 6'd11, 6'd44, 6'd13, 6'd14, 6'd28
   };

   typedef struct packed {
      logic [7:0] encoded_byte;
      logic       start_frame;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] decoded_byte;
      logic       byte_valid;
      logic       code_error;
   } rsp_payload_type;

   typedef struct packed {
      logic       hit;
      nibble_type nibble;
   } lookup_type;

   // Parallel compare against all sixteen codes; index of the match is the nibble.
   function automatic lookup_type sym_lookup(input symbol_type sym);
      lookup_type res;
      res = '0;
      for (int k = 0; k < CodeCount; k++) begin
         if (SymTable[k] == sym) begin
            res.hit    = 1'b1;
            res.nibble = NibbleWidth'(k);
         end
      end
      return res;
   endfunction

endpackage

// ----- design/fbsb_dec_core.sv -----
// Decoder core: bit accumulator, symbol lookup and nibble pairing state.
// Depends on fbsb_pkg.
module fbsb_dec_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  fbsb_pkg::req_payload_type item,
   output logic                     result_valid,
   output fbsb_pkg::rsp_payload_type result
);

   logic [fbsb_pkg::LineBitsWidth-1:0]  line_bits_ff, line_bits_in;
   logic [fbsb_pkg::LineCountWidth-1:0] line_count_ff, line_count_in;
   fbsb_pkg::nibble_type                pend_nib_ff, pend_nib_in;
   logic                                nib_wait_ff, nib_wait_in;

   logic [fbsb_pkg::LineBitsWidth-1:0]  bits_cur;
   logic [fbsb_pkg::LineCountWidth-1:0] cnt_cur;
   fbsb_pkg::nibble_type                pend_cur;
   logic                                wait_cur;
   logic [12:0]                         acc;
   logic [2:0]                          shamt1, shamt2;
   logic                                two_syms;
   fbsb_pkg::lookup_type                lk1, lk2;
   fbsb_pkg::nibble_type                pend_mid;
   logic                                wait_mid;
   logic                                byte1, byte2;
   logic [fbsb_pkg::LineCountWidth-1:0] cnt_rest;
   logic [5:0]                          rest_mask;
   logic                                err;

   always_comb begin
      // start flag clears state before the byte is used
      bits_cur = item.start_frame ? '0 : line_bits_ff;
      cnt_cur  = item.start_frame ? '0 : line_count_ff;
      pend_cur = item.start_frame ? '0 : pend_nib_ff;
      wait_cur = item.start_frame ? 1'b0 : nib_wait_ff;

      acc      = {bits_cur, item.encoded_byte};
      shamt1   = cnt_cur + 3'd2;
      shamt2   = cnt_cur - 3'd4;
      two_syms = (cnt_cur >= 3'd4);

      lk1 = fbsb_pkg::sym_lookup(fbsb_pkg::symbol_type'(acc >> shamt1));
      lk2 = fbsb_pkg::sym_lookup(fbsb_pkg::symbol_type'(acc >> shamt2));

      // first symbol
      byte1    = lk1.hit && wait_cur;
      pend_mid = wait_cur ? '0 : lk1.nibble;
      wait_mid = !wait_cur;

      // second symbol, only when twelve or more bits are present
      byte2 = lk1.hit && two_syms && lk2.hit && wait_mid;
      err   = !lk1.hit || (two_syms && !lk2.hit);

      result.code_error   = err;
      result.byte_valid   = byte1 || byte2;
      result.decoded_byte = byte2 ? {pend_mid, lk2.nibble} :
                            byte1 ? {pend_cur, lk1.nibble} : 8'd0;
      result_valid        = result.byte_valid || err;

      cnt_rest  = two_syms ? shamt2 : shamt1;
      rest_mask = (6'd1 << cnt_rest) - 6'd1;

      if (err) begin
         line_bits_in  = '0;
         line_count_in = '0;
         pend_nib_in   = '0;
         nib_wait_in   = 1'b0;
      end else begin
         line_bits_in  = acc[4:0] & rest_mask[4:0];
         line_count_in = cnt_rest;
         if (two_syms) begin
            pend_nib_in = wait_mid ? '0 : lk2.nibble;
            nib_wait_in = !wait_mid;
         end else begin
            pend_nib_in = pend_mid;
            nib_wait_in = wait_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_bits_ff  <= '0;
         line_count_ff <= '0;
         pend_nib_ff   <= '0;
         nib_wait_ff   <= 1'b0;
      end else if (advance) begin
         line_bits_ff  <= line_bits_in;
         line_count_ff <= line_count_in;
         pend_nib_ff   <= pend_nib_in;
         nib_wait_ff   <= nib_wait_in;
      end
   end

endmodule

// ----- design/four_b_six_b_decoder_top.sv -----
// 4b/6b line decoder top level: input register, decoder core, result register.
// Depends on fbsb_pkg and fbsb_dec_core.
//
// Usage:
//   Input channel (req_valid/req_ready/req_data) carries one received line byte,
//   MSB first, with a start_frame flag that clears the decoder before the byte.
//   Result channel (rsp_valid/rsp_ready/rsp_data) carries a decoded byte and/or
//   a code error flag. A line byte yields zero or one result transfer.
//   Each input byte is held in the input register, and its result then in the
//   result register. Throughput: one input byte per cycle while the receiver
//   does not stall the result register.
//   Bytes that complete no data byte and hit no error produce no transfer.
//   Reset clears the accumulator, the half-byte and both valid flags.
//   When the receiver stalls, the result register holds; the input register
//   fills and req_ready drops only while both stages are occupied, so nothing
//   is lost or repeated.
module four_b_six_b_decoder_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  fbsb_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output fbsb_pkg::rsp_payload_type rsp_data
);

   logic                      in_vld_ff, in_vld_in;
   fbsb_pkg::req_payload_type in_data_ff;
   logic                      out_vld_ff, out_vld_in;
   fbsb_pkg::rsp_payload_type out_data_ff;

   logic                      out_free;
   logic                      advance;
   logic                      core_vld;
   fbsb_pkg::rsp_payload_type core_res;

   // result slot is free when empty or being drained this cycle
   assign out_free  = !out_vld_ff || rsp_ready;
   assign advance   = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;

   fbsb_dec_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_data_ff),
      .result_valid (core_vld),
      .result       (core_res)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_ready) begin
         in_vld_in = req_valid;
      end
      out_vld_in = out_vld_ff;
      if (out_free) begin
         out_vld_in = advance && core_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance && core_vld) begin
         out_data_ff <= core_res;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- test/four_b_six_b_decoder_top_tb.sv -----
// Self-checking testbench for the 4b/6b line decoder top level.
// Depends on fbsb_pkg (payload types) and four_b_six_b_decoder_top.
// A local bit-level decoder predicts each result; a checker compares results in order.
module four_b_six_b_decoder_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // Input register plus result register between a transfer in and its result.
   localparam int PIPE_LATENCY = 2;
   localparam int RANDOM_LINE_BYTES = 900;
   localparam int DRAIN_LIMIT = 20000;

   localparam logic [5:0] SYMBOL_MASK = 6'h3F;
   // Line code for each nibble: the position in the list is the nibble value.
   localparam logic [5:0] LINE_CODES [16] = '{
      6'd21, 6'd49, 6'd50, 6'd35, 6'd52, 6'd37, 6'd38, 6'd22,
      6'd26, 6'd25, 6'd42, 6'd11, 6'd44, 6'd13, 6'd14, 6'd28
   };

   // Receiver behavior: always ready, short stalls, or long stalls.
   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   fbsb_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   fbsb_pkg::rsp_payload_type rsp_data;

   four_b_six_b_decoder_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Decoder state as the block should hold it: leftover line bits (low
   // held_count bits only), and the high nibble of an unfinished byte.
   logic [4:0] held_bits   = '0;
   int         held_count  = 0;
   logic [3:0] held_nibble = '0;
   logic       nibble_held = 1'b0;

   // Results still owed by the block, oldest first.
   fbsb_pkg::rsp_payload_type awaited_decodes [$];

   int failures        = 0;
   int line_bytes_sent = 0;
   int frames_sent     = 0;
   int bytes_checked   = 0;
   int errors_checked  = 0;
   int results_checked = 0;

   // Sender burst control.
   bit tx_gaps_on = 1'b0;
   int burst_left = 0;

   // Receiver stall pattern.
   rx_mode_type rx_mode  = RX_OPEN;
   int          rx_run   = 0;
   int          rx_stall = 0;

   function automatic void clear_decoder_model();
      held_bits   = '0;
      held_count  = 0;
      held_nibble = '0;
      nibble_held = 1'b0;
   endfunction

   // Nibble for a line code, or -1 when the code is not in the table.
   function automatic int nibble_of_symbol(input logic [5:0] sym);
      for (int k = 0; k < 16; k++) begin
         if (LINE_CODES[k] == sym) return k;
      end
      return -1;
   endfunction

   // Advances the decoder state by one line byte; returns 1 when a result is due.
   function automatic bit decode_line_byte(input fbsb_pkg::req_payload_type item,
                                           output fbsb_pkg::rsp_payload_type res);
      logic [12:0] line_acc;
      int          bit_count;
      logic [5:0]  sym;
      int          nib;
      bit          bad_code;
      res      = '0;
      bad_code = 1'b0;
      // start flag clears everything before the byte is looked at
      if (item.start_frame) clear_decoder_model();
      line_acc  = {held_bits, item.encoded_byte};
      bit_count = held_count + 8;
      while (bit_count >= 6 && !bad_code) begin
         sym = 6'((line_acc >> (bit_count - 6)) & 13'(SYMBOL_MASK));
         nib = nibble_of_symbol(sym);
         if (nib < 0) begin
            // decoding stops here; any byte finished just before still reports
            bad_code = 1'b1;
         end else begin
            bit_count -= 6;
            if (nibble_held) begin
               res.decoded_byte = {held_nibble, 4'(nib)};
               res.byte_valid   = 1'b1;
               held_nibble      = '0;
               nibble_held      = 1'b0;
            end else begin
               held_nibble = 4'(nib);
               nibble_held = 1'b1;
            end
         end
      end
      if (bad_code) begin
         clear_decoder_model();
         res.code_error = 1'b1;
      end else begin
         held_count = bit_count;
         held_bits  = 5'(line_acc & ((13'd1 << bit_count) - 13'd1));
      end
      return res.byte_valid || res.code_error;
   endfunction

   // Any 6-bit value that is not a line code.
   function automatic logic [5:0] random_bad_symbol();
      logic [5:0] sym;
      sym = 6'($urandom_range(0, 63));
      while (nibble_of_symbol(sym) >= 0) sym = 6'($urandom_range(0, 63));
      return sym;
   endfunction

   // One line byte over the input channel; the prediction is made on the
   // transfer edge. Valid stays high across back-to-back transfers.
   task automatic send_line_byte(input logic [7:0] line_byte, input logic frame_start);
      fbsb_pkg::req_payload_type item;
      fbsb_pkg::rsp_payload_type res;
      int                        gap;
      item.encoded_byte = line_byte;
      item.start_frame  = frame_start;
      if (tx_gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      line_bytes_sent++;
      if (decode_line_byte(item, res)) awaited_decodes.push_back(res);
   endtask

   // Encodes data bytes into line bytes, high nibble first, and sends them as
   // one frame. bad_index picks a symbol to replace with a non-code (-1: none).
   // The tail is padded with random bits up to a whole line byte.
   task automatic send_frame(input logic [7:0] data [$], input int bad_index);
      bit         line_bits [$];
      logic [5:0] sym;
      logic [7:0] line_byte;
      int         sym_index;
      sym_index = 0;
      foreach (data[i]) begin
         for (int half = 0; half < 2; half++) begin
            sym = LINE_CODES[half == 0 ? data[i][7:4] : data[i][3:0]];
            if (sym_index == bad_index) sym = random_bad_symbol();
            for (int b = 5; b >= 0; b--) line_bits.push_back(sym[b]);
            sym_index++;
         end
      end
      while (line_bits.size() % 8 != 0) line_bits.push_back(bit'($urandom_range(0, 1)));
      for (int n = 0; n < line_bits.size() / 8; n++) begin
         for (int b = 0; b < 8; b++) line_byte[7-b] = line_bits[n*8+b];
         send_line_byte(line_byte, n == 0);
      end
      frames_sent++;
   endtask

   // Holds the input channel idle until every owed result has come, then lets
   // the pipeline settle.
   task automatic wait_for_decodes();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (awaited_decodes.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // Result checker and receiver stall pattern, both on the sampling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_decodes.size() == 0) begin
            failures++;
            $display("%0t: unexpected result transfer, expected none, actual %h",
                     $time, rsp_data);
         end else begin
            fbsb_pkg::rsp_payload_type want;
            want = awaited_decodes.pop_front();
            results_checked++;
            if (want.byte_valid) bytes_checked++;
            if (want.code_error) errors_checked++;
            if (rsp_data.decoded_byte !== want.decoded_byte) begin
               failures++;
               $display("%0t: decoded_byte mismatch, expected %h, actual %h",
                        $time, want.decoded_byte, rsp_data.decoded_byte);
            end
            if (rsp_data.byte_valid !== want.byte_valid) begin
               failures++;
               $display("%0t: byte_valid mismatch, expected %b, actual %b",
                        $time, want.byte_valid, rsp_data.byte_valid);
            end
            if (rsp_data.code_error !== want.code_error) begin
               failures++;
               $display("%0t: code_error mismatch, expected %b, actual %b",
                        $time, want.code_error, rsp_data.code_error);
            end
         end
      end
      if (rx_mode == RX_OPEN) begin
         rsp_ready <= 1'b1;
      end else if (rx_run > 0) begin
         rsp_ready <= 1'b1;
         rx_run--;
      end else if (rx_stall > 0) begin
         rsp_ready <= 1'b0;
         rx_stall--;
      end else begin
         // new run/stall pair; heavy mode stalls long and runs short
         rx_run   = (rx_mode == RX_HEAVY) ? $urandom_range(0, 2) : $urandom_range(0, 8);
         rx_stall = (rx_mode == RX_HEAVY) ? $urandom_range(3, 12) : $urandom_range(1, 3);
         rsp_ready <= 1'b1;
      end
   end

   // All-zero and all-one line bytes: neither leading symbol is a code.
   task automatic test_line_extremes();
      send_line_byte(8'h00, 1'b1);
      send_line_byte(8'hFF, 1'b1);
   endtask

   // Every nibble through the table once, in a clean frame.
   task automatic test_all_codes();
      logic [7:0] data [$];
      data = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
      send_frame(data, -1);
   endtask

   // 0x55 leaves a high nibble waiting with no result; the next frame's start
   // flag must drop it.
   task automatic test_frame_restart();
      logic [7:0] data [$];
      data = '{8'hA5, 8'h3C};
      send_line_byte(8'h55, 1'b0);
      send_frame(data, -1);
   endtask

   // Bad code as the second symbol inside one line byte: the first data byte
   // comes out, then an error that clears the state.
   task automatic test_bad_symbol();
      logic [7:0] data [$];
      data = '{8'h5A, 8'hC3};
      send_frame(data, 3);
   endtask

   // Sender stops until the pipeline is empty, then resumes at full rate.
   task automatic test_pause_for_results();
      logic [7:0] data [$];
      data = '{8'h96, 8'h0F, 8'hF0};
      send_frame(data, -1);
      wait_for_decodes();
      send_frame(data, -1);
   endtask

   // Mostly well-formed frames with random data (some carrying a bad symbol),
   // mixed with raw line bytes and stray start flags.
   task automatic test_random_traffic(input int line_count, input bit gaps,
                                      input rx_mode_type rx);
      logic [7:0] data [$];
      int         stop_at;
      int         data_count;
      int         bad_index;
      tx_gaps_on = gaps;
      rx_mode    = rx;
      stop_at    = line_bytes_sent + line_count;
      while (line_bytes_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7) begin
            data.delete();
            data_count = $urandom_range(1, 6);
            repeat (data_count) data.push_back(8'($urandom_range(0, 255)));
            bad_index = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * data_count - 1) : -1;
            send_frame(data, bad_index);
         end else begin
            repeat ($urandom_range(1, 4))
               send_line_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part at full rate with a steady receiver
      test_line_extremes();
      test_all_codes();
      test_frame_restart();
      test_bad_symbol();

      rx_mode = RX_LIGHT;
      test_pause_for_results();

      test_random_traffic(RANDOM_LINE_BYTES / 3, 1'b1, RX_LIGHT);
      test_random_traffic(RANDOM_LINE_BYTES / 3, 1'b0, RX_OPEN);
      test_random_traffic(RANDOM_LINE_BYTES / 3, 1'b1, RX_HEAVY);

      wait_for_decodes();
      if (awaited_decodes.size() != 0) begin
         failures++;
         $display("%0t: %0d results never arrived, expected %h, actual none",
                  $time, awaited_decodes.size(), awaited_decodes[0]);
      end
      $display("Sent %0d line bytes in %0d frames plus raw bytes under three stall patterns.",
               line_bytes_sent, frames_sent);
      $display("Checked %0d results: %0d data bytes, %0d code errors.",
               results_checked, bytes_checked, errors_checked);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/fbsb_pkg.sv
design/fbsb_dec_core.sv
design/four_b_six_b_decoder_top.sv
test/four_b_six_b_decoder_top_tb.sv
